// ----- src/fte_pkg.sv -----
package fte_pkg;

   // Table geometry: two 12-bit entries share one 24-bit row of three bytes
   localparam int MaxEntries  = 4096;
   localparam int TableBytes  = (3 * MaxEntries + 1) / 2;
   localparam int Rows        = MaxEntries / 2;
   localparam int RowBits     = $clog2(Rows);
   localparam int EntryBits   = 12;
   localparam int AddrBits    = 13;
   localparam int CountBits   = 13;
   localparam int RowWidth    = 24;

   localparam logic [CountBits-1:0] ResetEntries = 13'd3072;
   localparam logic [CountBits-1:0] LimitMax     = 13'd4096;
   localparam logic [AddrBits-1:0]  ByteLimit    = 13'd6144;

   // floor(a / 3) == (a * Recip3) >> Recip3Shift for every a below 8192
   localparam logic [11:0] Recip3      = 12'd2731;
   localparam int          Recip3Shift = 13;

   // Request kinds
   localparam logic [2:0] REQ_READ_ENTRY  = 3'd0;
   localparam logic [2:0] REQ_WRITE_ENTRY = 3'd1;
   localparam logic [2:0] REQ_FIND_FREE   = 3'd2;
   localparam logic [2:0] REQ_READ_BYTE   = 3'd3;
   localparam logic [2:0] REQ_WRITE_BYTE  = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_NONE_FREE = 2'd2;
   localparam logic [1:0] STATUS_UNUSED    = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

// ----- src/fat12_table_engine_top.sv -----
// FAT12 allocation table engine.
// Requests enter on the req_ stream (kind in req_tuser, operands in req_tdata),
// one result leaves per request on the rsp_ stream (status in rsp_tuser).
// The table lives in one 2048 x 24-bit synchronous RAM; each row holds the
// three packed bytes of an even/odd entry pair, so any entry is one row read.
// An entry or raw byte request is accepted in ST_IDLE, which issues the row read;
// ST_EXEC then builds the result and writes the modified row back.
// A find-free request walks the rows from the given entry, one row (two entries)
// checked per cycle, until it meets a zero entry or reaches the limit.
// The entry count register is written on the csr_ port, which is always ready;
// write it only while no request is in flight.
// After reset all 2048 rows of the RAM are swept to zero, one row per cycle;
// req_tready stays low during that pass. The entry count resets to 3072.
// The result sits in an output register; a new request may be accepted while
// it waits. If rsp_tready stays low, the next result holds in the engine and
// no further request is accepted until the output register frees up.
module fat12_table_engine_top
   import fte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // entry_index[11:0], byte_address[24:12],
                                   // write_value[36:25], zero fill[39:37]
   input  logic [2:0]  req_tuser,  // req_type[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // read_value[11:0], found_index[23:12]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CountBits-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [RowBits-1:0]   clr_row_ff, clr_row_in;
   logic [CountBits-1:0] entries_ff;

   logic [2:0]           kind_ff;
   logic [EntryBits-1:0] idx_ff, idx_in;
   logic [AddrBits-1:0]  addr_ff;
   logic [EntryBits-1:0] wval_ff;
   logic [RowBits-1:0]   brow_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   logic [RowWidth-1:0]  mem [Rows];
   logic [RowWidth-1:0]  rdata_ff;
   logic                 rd_en;
   logic [RowBits-1:0]   rd_row;
   logic                 mem_we;
   logic [RowBits-1:0]   wr_row;
   logic [RowWidth-1:0]  wdata;

   logic                 accept;
   logic [EntryBits-1:0] req_idx;
   logic [AddrBits-1:0]  req_addr;
   logic [24:0]          byte_prod;
   logic [11:0]          byte_row_full;
   logic                 req_is_byte;

   logic [CountBits-1:0] lim;
   logic                 out_free;
   logic [AddrBits-1:0]  lane_diff;
   logic [1:0]           lane;
   logic [7:0]           byte_sel;
   logic                 idx_ok;
   logic                 addr_ok;
   logic [EntryBits-1:0] hi_idx;
   logic                 lo_hit;
   logic                 hi_hit;
   logic [CountBits-1:0] next_idx;
   logic                 more;

   logic                 done;
   logic                 we_req;
   logic [RowWidth-1:0]  new_word;
   logic [EntryBits-1:0] res_read;
   logic [EntryBits-1:0] res_found;
   logic [1:0]           res_status;

   assign req_idx  = req_tdata[11:0];
   assign req_addr = req_tdata[24:12];
   assign accept   = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Limit in force: smaller of the register and the table size
   assign lim = (entries_ff > LimitMax) ? LimitMax : entries_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Row of a raw byte address by reciprocal multiply
   assign byte_prod     = 25'(req_addr) * 25'(Recip3);
   assign byte_row_full = byte_prod[24:Recip3Shift];

   // Byte lane inside the row: addr - 3 * row
   assign lane_diff = addr_ff - ({1'b0, brow_ff, 1'b0} + {2'b00, brow_ff});
   assign lane      = lane_diff[1:0];

   always_comb begin
      case (lane)
         2'd0:    byte_sel = rdata_ff[7:0];
         2'd1:    byte_sel = rdata_ff[15:8];
         default: byte_sel = rdata_ff[23:16];
      endcase
   end

   assign idx_ok  = ({1'b0, idx_ff} < lim);
   assign addr_ok = (addr_ff < ByteLimit);

   // Search step over one row: even entry, then the odd one
   assign hi_idx   = {idx_ff[EntryBits-1:1], 1'b1};
   assign lo_hit   = !idx_ff[0] && (rdata_ff[11:0] == 12'h000);
   assign hi_hit   = ({1'b0, hi_idx} < lim) && (rdata_ff[23:12] == 12'h000);
   assign next_idx = {1'b0, hi_idx} + 13'd1;
   assign more     = (next_idx < lim);

   // Build the result and the modified row from the row just read
   always_comb begin
      done       = 1'b1;
      we_req     = 1'b0;
      new_word   = rdata_ff;
      res_read   = '0;
      res_found  = '0;
      res_status = STATUS_OK;
      case (kind_ff)
         REQ_READ_ENTRY: begin
            if (!idx_ok) begin
               res_status = STATUS_RANGE;
            end else begin
               res_read = idx_ff[0] ? rdata_ff[23:12] : rdata_ff[11:0];
            end
         end
         REQ_WRITE_ENTRY: begin
            if (!idx_ok) begin
               res_status = STATUS_RANGE;
            end else begin
               we_req = 1'b1;
               if (idx_ff[0]) begin
                  new_word = {wval_ff, rdata_ff[11:0]};
               end else begin
                  new_word = {rdata_ff[23:12], wval_ff};
               end
            end
         end
         REQ_FIND_FREE: begin
            if (!idx_ok) begin
               res_status = STATUS_RANGE;
            end else if (lo_hit) begin
               res_found = idx_ff;
            end else if (hi_hit) begin
               res_found = hi_idx;
            end else if (more) begin
               done = 1'b0;
            end else begin
               res_status = STATUS_NONE_FREE;
            end
         end
         REQ_READ_BYTE: begin
            if (!addr_ok) begin
               res_status = STATUS_RANGE;
            end else begin
               res_read = {4'h0, byte_sel};
            end
         end
         REQ_WRITE_BYTE: begin
            if (!addr_ok) begin
               res_status = STATUS_RANGE;
            end else begin
               we_req = 1'b1;
               case (lane)
                  2'd0:    new_word = {rdata_ff[23:8], wval_ff[7:0]};
                  2'd1:    new_word = {rdata_ff[23:16], wval_ff[7:0], rdata_ff[7:0]};
                  default: new_word = {wval_ff[7:0], rdata_ff[15:0]};
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Next state, RAM control and output register load
   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rd_en        = 1'b0;
      rd_row       = req_idx[EntryBits-1:1];
      mem_we       = 1'b0;
      wr_row       = clr_row_ff;
      wdata        = '0;
      req_is_byte  = (req_tuser inside {REQ_READ_BYTE, REQ_WRITE_BYTE});
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == RowBits'(Rows - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rd_en    = 1'b1;
               rd_row   = req_is_byte ? byte_row_full[RowBits-1:0]
                                      : req_idx[EntryBits-1:1];
               idx_in   = req_idx;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!done) begin
               // advance the search to the next row
               rd_en  = 1'b1;
               rd_row = next_idx[EntryBits-1:1];
               idx_in = next_idx[EntryBits-1:0];
            end else if (out_free) begin
               mem_we       = we_req;
               wr_row       = (kind_ff == REQ_WRITE_BYTE) ? brow_ff
                                                          : idx_ff[EntryBits-1:1];
               wdata        = new_word;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_found, res_read};
               rsp_user_in  = res_status;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_row_ff   <= '0;
         entries_ff   <= ResetEntries;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            entries_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (accept) begin
         kind_ff <= req_tuser;
         addr_ff <= req_addr;
         wval_ff <= req_tdata[36:25];
         brow_ff <= byte_row_full[RowBits-1:0];
      end
   end

   // Table RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_row] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_row];
      end
   end

   // The RAM is written only while clearing or finishing a request
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE))
      else $error("table written while idle");

   // An accepted item always moves into execution
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item did not enter execution");

   // A new result comes only out of execution
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result appeared outside execution");

   // The unused status code is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_user_ff != STATUS_UNUSED))
      else $error("unused status code on result");

endmodule
